/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, held off during reset.
`define FCQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same check, also evaluated while reset is asserted.
`define FCQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/fcq_pkg.sv */
// Shared constants, types and codes of the circular FIFO queue.
`timescale 1ns / 1ps

package fcq_pkg;

    localparam int DEPTH  = 64;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = 7;
    localparam int WORD_W = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic signed [WORD_W-1:0] ERR_WORD = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_REPLY
    } fsm_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [WORD_W-1:0] wr_data;
    } ring_req_t;

    typedef struct packed {
        logic [PTR_W-1:0]  slot;
        logic [WORD_W-1:0] rd_data;
    } ring_rsp_t;

endpackage

/* rtl/fcq_cell.sv */
// One storage cell of the rotating word ring.
`timescale 1ns / 1ps

module fcq_cell
    import fcq_pkg::*;
(
    input  logic              clk,
    input  logic [WORD_W-1:0] d_in,
    output logic [WORD_W-1:0] d_out
);

    logic [WORD_W-1:0] data_reg;

    // Take the neighbor's word on every edge.
    always_ff @(posedge clk)
    begin
        data_reg <= d_in;
    end

    assign d_out = data_reg;

endmodule

/* rtl/fcq_ring.sv */
// Rotating ring of word cells with a slot counter for the access port.
`timescale 1ns / 1ps

module fcq_ring
    import fcq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ring_req_t ring_req,
    output ring_rsp_t ring_rsp
);

    logic [WORD_W-1:0] cell_q [DEPTH];
    logic [WORD_W-1:0] cell_d [DEPTH];
    logic [PTR_W-1:0]  rot_reg;
    logic [PTR_W-1:0]  rot_next;

    // Cell k holds slot (rot + k) mod DEPTH; the head cell is the access port.
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            if (k == DEPTH - 1)
            begin : g_wrap
                assign cell_d[k] = ring_req.wr_en ? ring_req.wr_data : cell_q[0];
            end
            else
            begin : g_pass
                assign cell_d[k] = cell_q[k+1];
            end

            fcq_cell u_cell (
                .clk   (clk),
                .d_in  (cell_d[k]),
                .d_out (cell_q[k])
            );
        end
    endgenerate

    assign rot_next = (rot_reg == PTR_W'(DEPTH - 1)) ? '0 : rot_reg + PTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg <= '0;
        end
        else
        begin
            rot_reg <= rot_next;
        end
    end

    assign ring_rsp.slot    = rot_reg;
    assign ring_rsp.rd_data = cell_q[0];

endmodule

/* rtl/fcq_ctrl.sv */
// Command sequencer, pointers, fill count and result registers.
`timescale 1ns / 1ps

module fcq_ctrl
    import fcq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [WORD_W-1:0] item,
    input  logic                     capacity_we,
    input  logic [CNT_W-1:0]         capacity,
    output logic                     busy,
    output logic                     done,
    output logic [STAT_W-1:0]        status,
    output logic signed [WORD_W-1:0] data,
    output logic                     is_empty,
    output logic                     is_full,
    output logic [CNT_W-1:0]         count,
    output ring_req_t                ring_req,
    input  ring_rsp_t                ring_rsp
);

    fsm_state_t state_reg, state_next;

    logic [CNT_W-1:0]         cap_reg;
    logic [PTR_W-1:0]         head_reg;
    logic [PTR_W-1:0]         tail_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [CMD_W-1:0]         cmd_reg;
    logic [WORD_W-1:0]        item_reg;
    logic [PTR_W-1:0]         target_reg;
    logic [STAT_W-1:0]        status_reg;
    logic signed [WORD_W-1:0] data_reg;

    logic [CNT_W-1:0]  eff_cap;
    logic              empty_now;
    logic              full_now;
    logic              accept;
    logic              hit;
    logic              needs_access;
    logic [STAT_W-1:0] accept_status;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                     input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] p1;
        p1 = CNT_W'(p) + CNT_W'(1);
        return (p1 >= cap) ? '0 : p1[PTR_W-1:0];
    endfunction

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CNT_W'(1);
        else if (cap_reg > CNT_W'(DEPTH))
            eff_cap = CNT_W'(DEPTH);
        else
            eff_cap = cap_reg;
    end

    assign empty_now = (fill_reg == '0);
    assign full_now  = (fill_reg >= eff_cap);
    assign accept    = start && (state_reg == ST_IDLE);
    assign hit       = (state_reg == ST_SEEK) && (ring_rsp.slot == target_reg);

    always_comb
    begin
        needs_access  = 1'b0;
        accept_status = STAT_OK;
        unique case (command) inside
            CMD_ENQ:
            begin
                needs_access  = !full_now;
                accept_status = full_now ? STAT_FULL : STAT_OK;
            end
            CMD_DEQ, CMD_PEEK:
            begin
                needs_access  = !empty_now;
                accept_status = empty_now ? STAT_EMPTY : STAT_OK;
            end
            default:
            begin
                needs_access  = 1'b0;
                accept_status = STAT_OK;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = needs_access ? ST_SEEK : ST_REPLY;
            end
            ST_SEEK:
            begin
                if (hit)
                    state_next = ST_REPLY;
            end
            ST_REPLY: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy             = (state_reg != ST_IDLE);
        done             = (state_reg == ST_REPLY);
        ring_req.wr_en   = hit && (cmd_reg == CMD_ENQ);
        ring_req.wr_data = item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_RESET;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (capacity_we)
                cap_reg <= capacity;
            if (hit)
            begin
                if (cmd_reg == CMD_ENQ)
                begin
                    tail_reg <= ptr_advance(tail_reg, eff_cap);
                    fill_reg <= fill_reg + CNT_W'(1);
                end
                else if (cmd_reg == CMD_DEQ)
                begin
                    head_reg <= ptr_advance(head_reg, eff_cap);
                    fill_reg <= fill_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            item_reg   <= item;
            target_reg <= (command == CMD_ENQ) ? tail_reg : head_reg;
            status_reg <= accept_status;
            data_reg   <= ERR_WORD;
        end
        else if (hit && (cmd_reg != CMD_ENQ))
        begin
            data_reg <= $signed(ring_rsp.rd_data);
        end
    end

    assign status   = status_reg;
    assign data     = data_reg;
    assign count    = fill_reg;
    assign is_empty = empty_now;
    assign is_full  = full_now;

endmodule

/* rtl/circular_fifo_queue.sv */
// Top level of the circular FIFO queue of signed 32-bit words.
`timescale 1ns / 1ps

// Circular FIFO queue. Issue a command by raising start while busy is low;
// the command beat (command, item) is taken on that edge and busy stays high
// until the result is out. Each command returns exactly one result beat,
// shown for a single cycle with done high: status, data (-1 on an enqueue,
// a rejected command or the unused code), is_empty, is_full and count as
// they stand after the command. The receiver cannot stall, so capture the
// result on the cycle done is high. A command that does not touch the store
// (a rejected command or the unused code) skips the seek state; one that
// does waits there until its slot reaches the head. The words sit in a ring
// of DEPTH cells that rotates by one cell every cycle, and the single access
// port at the ring's head reaches a given slot only when it comes around, so
// the wait is set by the distance between the ring's position and the head
// or tail pointer. Write capacity (0 acts as 1, above DEPTH acts as DEPTH)
// only while busy is low; contents and pointers are kept across such a write.
module circular_fifo_queue
    import fcq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [WORD_W-1:0] item,
    input  logic                     capacity_we,
    input  logic [CNT_W-1:0]         capacity,
    output logic                     busy,
    output logic                     done,
    output logic [STAT_W-1:0]        status,
    output logic signed [WORD_W-1:0] data,
    output logic                     is_empty,
    output logic                     is_full,
    output logic [CNT_W-1:0]         count
);

    // Access port requests go from the sequencer into the ring; the ring
    // answers with the slot now at its head and the word it holds.
    ring_req_t ring_req;
    ring_rsp_t ring_rsp;

    // Hold the command, seek the slot, then drop the result beat.
    fcq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .item        (item),
        .capacity_we (capacity_we),
        .capacity    (capacity),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .data        (data),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .count       (count),
        .ring_req    (ring_req),
        .ring_rsp    (ring_rsp)
    );

    // Advance the word ring every cycle; writes enter at the wrap point.
    fcq_ring u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ring_req (ring_req),
        .ring_rsp (ring_rsp)
    );

endmodule

/* rtl/fcq_checker.sv */
// Port-level checker of the circular FIFO queue and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcq_checker
    import fcq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic [STAT_W-1:0]        status,
    input logic signed [WORD_W-1:0] data,
    input logic                     is_empty,
    input logic                     is_full,
    input logic [CNT_W-1:0]         count
);

    `FCQ_ASSERT(a_accept_busy, clk, rst_n, start && !busy |=> busy, "accept did not raise busy")
    `FCQ_ASSERT(a_done_ends, clk, rst_n, done |=> !busy && !done, "result beat not single")
    `FCQ_ASSERT(a_empty_count, clk, rst_n, done |-> (is_empty == (count == '0)), "empty flag off")
    `FCQ_ASSERT(a_err_word, clk, rst_n, done && (status != STAT_OK) |-> (data == ERR_WORD), "bad error data")
    `FCQ_ASSERT_ALWAYS(a_flags, clk, !rst_n || !done || !(is_empty && is_full), "empty and full")

endmodule

bind circular_fifo_queue fcq_checker u_fcq_checker (.*);
